// ===== rtl/cpd_pkg.sv =====
// shared types and constants for the candlestick pattern detector
package cpd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int PCT_W     = 7;
  localparam int CNT_W     = 3;
  localparam int FIELD_W   = 32;
  localparam int NUM_OUT   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_BODY  = 2'd1;

  localparam logic [PCT_W-1:0] SHORT_WICK_RST = 7'd30;
  localparam logic [PCT_W-1:0] LONG_BODY_RST  = 7'd33;

  localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

  typedef struct packed {
    logic green;
    logic red;
    logic long_body;
    logic short_upper;
    logic short_lower;
  } candle_flags_t;

  typedef struct packed {
    logic black_crows;
    logic white_soldiers;
    logic star;
    logic piercing_line;
    logic engulfing;
    logic inverse_hammer;
    logic hammer;
    logic window_ready;
  } pattern_flags_t;

endpackage

// ===== rtl/candlestick_pattern_detector.sv =====
// Candlestick pattern detector: one OHLC candle per in_ transaction gives one flag
// byte per out_ transaction. A candle is taken into the three-candle window register
// and its flags are then registered in the output register. One candle can be taken
// every cycle; only out_tready holding off a full output register stalls the input.
// The single combinational pass between the two registers holds a W-by-7-bit multiply
// and compare per ratio test. Pattern flags stay low until MIN_HISTORY earlier candles
// of the series have been seen; in_tuser high starts a new series. Ratio registers are
// written on cfg_; the user must keep writes to idle, as the block does not enforce it.
module candlestick_pattern_detector #(
  parameter int PRICE_WIDTH = 32,
  parameter int MIN_HISTORY = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // open_price, high_price, low_price, close_price
  input  logic [4*cpd_pkg::FIELD_W-1:0]   in_tdata,
  // first_of_series
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // window_ready, hammer, inverse_hammer, engulfing, piercing_line, star,
  // white_soldiers, black_crows
  output logic [cpd_pkg::NUM_OUT-1:0]     out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpd_pkg::PCT_W-1:0]       cfg_wdata
);
  import cpd_pkg::*;

  localparam int UW = (PRICE_WIDTH < FIELD_W) ? PRICE_WIDTH : FIELD_W;
  localparam logic [CNT_W-1:0] MIN_HIST = CNT_W'(MIN_HISTORY);

  logic [PCT_W-1:0]   short_pct_r;
  logic [PCT_W-1:0]   long_pct_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_eff;
  logic               win_valid_r;
  logic               ready_r;
  logic [2:0][UW-1:0] open_r;
  logic [2:0][UW-1:0] high_r;
  logic [2:0][UW-1:0] low_r;
  logic [2:0][UW-1:0] close_r;
  logic               out_valid_r;
  pattern_flags_t     out_data_r;

  logic               in_acc;
  logic               advance;
  logic [2:0][UW-1:0] body_w;
  logic [2:0][UW-1:0] lwick_w;
  logic [2:0][UW-1:0] uwick_w;
  candle_flags_t [2:0] cflags;
  pattern_flags_t     pat_w;

  assign advance   = win_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !win_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cnt_eff   = in_tuser ? '0 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_pct_r <= SHORT_WICK_RST;
      long_pct_r  <= LONG_BODY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_WICK: short_pct_r <= cfg_wdata;
        REG_LONG_BODY:  long_pct_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      win_valid_r <= 1'b0;
      ready_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        win_valid_r <= 1'b1;
        ready_r     <= cnt_eff >= MIN_HIST;
        cnt_r       <= (cnt_eff == COUNT_MAX) ? COUNT_MAX : cnt_eff + 1'b1;
      end else if (advance) begin
        win_valid_r <= 1'b0;
      end
    end
  end

  // window shifts on every accepted candle, index 0 is the newest
  always_ff @(posedge clk) begin
    if (in_acc) begin
      open_r  <= {open_r[1],  open_r[0],  in_tdata[UW-1:0]};
      high_r  <= {high_r[1],  high_r[0],  in_tdata[FIELD_W+UW-1:FIELD_W]};
      low_r   <= {low_r[1],   low_r[0],   in_tdata[2*FIELD_W+UW-1:2*FIELD_W]};
      close_r <= {close_r[1], close_r[0], in_tdata[3*FIELD_W+UW-1:3*FIELD_W]};
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_metrics
    cpd_candle_metrics #(.W(UW)) u_metrics (
      .open_p     (open_r[g]),
      .high_p     (high_r[g]),
      .low_p      (low_r[g]),
      .close_p    (close_r[g]),
      .short_pct  (short_pct_r),
      .long_pct   (long_pct_r),
      .body       (body_w[g]),
      .lower_wick (lwick_w[g]),
      .upper_wick (uwick_w[g]),
      .flags      (cflags[g])
    );
  end

  cpd_pattern_logic #(.W(UW)) u_patterns (
    .ready       (ready_r),
    .open_p      (open_r),
    .high_p      (high_r),
    .low_p       (low_r),
    .close_p     (close_r),
    .body        (body_w),
    .lower_wick0 (lwick_w[0]),
    .upper_wick0 (uwick_w[0]),
    .flags       (cflags),
    .result      (pat_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= pat_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no pattern is reported before the history window is full
  a_flags_need_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] || (out_tdata[7:1] == '0)))
    else $error("pattern flag raised without window_ready");

  // a new series restarts the count at one
  a_series_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> (cnt_r == CNT_W'(1)))
    else $error("series start did not restart the count");

  // no candle is taken while both the window and output registers are stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (win_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline is full");

  // rising and falling three-candle runs exclude each other
  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("soldiers and crows reported together");

endmodule

// ===== rtl/cpd_candle_metrics.sv =====
// body, wicks and shape flags of one candle
module cpd_candle_metrics #(
  parameter int W = 32
) (
  input  logic [W-1:0]                   open_p,
  input  logic [W-1:0]                   high_p,
  input  logic [W-1:0]                   low_p,
  input  logic [W-1:0]                   close_p,
  input  logic [cpd_pkg::PCT_W-1:0]      short_pct,
  input  logic [cpd_pkg::PCT_W-1:0]      long_pct,
  output logic [W-1:0]                   body,
  output logic [W-1:0]                   lower_wick,
  output logic [W-1:0]                   upper_wick,
  output cpd_pkg::candle_flags_t         flags
);
  import cpd_pkg::*;

  localparam int PW = W + PCT_W;

  logic [W-1:0]  lo_v;
  logic [W-1:0]  hi_v;
  logic [PW-1:0] up100;
  logic [PW-1:0] lo100;
  logic [PW-1:0] body_long;
  logic [PW-1:0] body_short;

  // wick * 100 as shifts and adds
  function automatic logic [PW-1:0] times100(input logic [W-1:0] v);
    logic [PW-1:0] x;
    x = PW'(v);
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

  always_comb begin
    lo_v = (close_p < open_p) ? close_p : open_p;
    hi_v = (close_p < open_p) ? open_p : close_p;
    body       = (close_p > open_p) ? close_p - open_p : open_p - close_p;
    lower_wick = (low_p > lo_v) ? low_p - lo_v : lo_v - low_p;
    upper_wick = (high_p > hi_v) ? high_p - hi_v : hi_v - high_p;
    up100      = times100(upper_wick);
    lo100      = times100(lower_wick);
    body_long  = PW'(body) * PW'(long_pct);
    body_short = PW'(body) * PW'(short_pct);
    flags.green       = close_p > open_p;
    flags.red         = close_p < open_p;
    flags.long_body   = (lo100 < body_long) && (up100 < body_long);
    flags.short_upper = up100 < body_short;
    flags.short_lower = lo100 < body_short;
  end

endmodule

// ===== rtl/cpd_pattern_logic.sv =====
// pattern tests over the newest three candles
module cpd_pattern_logic #(
  parameter int W = 32
) (
  input  logic                          ready,
  input  logic [2:0][W-1:0]             open_p,
  input  logic [2:0][W-1:0]             high_p,
  input  logic [2:0][W-1:0]             low_p,
  input  logic [2:0][W-1:0]             close_p,
  input  logic [2:0][W-1:0]             body,
  input  logic [W-1:0]                  lower_wick0,
  input  logic [W-1:0]                  upper_wick0,
  input  cpd_pkg::candle_flags_t [2:0]  flags,
  output cpd_pkg::pattern_flags_t       result
);
  import cpd_pkg::*;

  logic [W:0] twice_close0;
  logic [W:0] sum_prev;

  always_comb begin
    twice_close0 = {close_p[0], 1'b0};
    sum_prev     = {1'b0, close_p[1]} + {1'b0, open_p[1]};

    result.window_ready   = ready;
    result.hammer         = ready && (body[0] < lower_wick0) && flags[0].short_upper;
    result.inverse_hammer = ready && (body[0] < upper_wick0) && flags[0].short_lower;
    result.engulfing      = ready && (body[0] > body[1]) && (high_p[0] > high_p[1]) &&
                            (low_p[0] < low_p[1]) && flags[0].green && flags[1].red;
    result.piercing_line  = ready && flags[0].long_body && flags[1].long_body &&
                            flags[0].green && flags[1].red && (twice_close0 > sum_prev);
    result.star           = ready && flags[0].green && (body[1] < body[0]) &&
                            (open_p[1] < open_p[0]) && (close_p[1] < open_p[0]) &&
                            flags[2].red && (body[2] > body[1]) &&
                            (open_p[1] < close_p[2]) && (close_p[1] < close_p[2]);
    result.white_soldiers = ready && flags[0].green && flags[1].green && flags[2].green &&
                            flags[0].long_body && flags[1].long_body && flags[2].long_body &&
                            (open_p[0] > open_p[1]) && (close_p[0] > close_p[1]) &&
                            (open_p[1] > open_p[2]) && (close_p[1] > close_p[2]);
    result.black_crows    = ready && flags[0].red && flags[1].red && flags[2].red &&
                            flags[0].long_body && flags[1].long_body && flags[2].long_body &&
                            (open_p[0] < open_p[1]) && (close_p[0] < close_p[1]) &&
                            (open_p[1] < open_p[2]) && (close_p[1] < close_p[2]);
  end

endmodule

// ===== sim/tb_candlestick_pattern_detector.sv =====
// self-checking testbench for the candlestick pattern detector
`timescale 1ns / 100ps

module tb_candlestick_pattern_detector;
  import cpd_pkg::*;

  localparam int MIN_HISTORY = 5;
  localparam int PHASE_ITEMS = 125;
  localparam int NUM_PHASES  = 6;

  // indexes with no register behind them, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam pattern_flags_t NOT_READY = '0;

  typedef logic [FIELD_W-1:0] price_t;

  typedef struct packed {
    logic   first;
    price_t open;
    price_t high;
    price_t low;
    price_t close;
  } candle_t;

  typedef struct packed {
    candle_t        cd;
    logic           typed;
    pattern_flags_t flags;
  } dir_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // history still filling after reset, extremes and malformed candles
    '{'{1'b0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, NOT_READY},
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, NOT_READY},
    '{'{1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0}, 1'b1, NOT_READY},
    '{'{1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF}, 1'b1, NOT_READY},
    // new series, count cleared
    '{'{1'b1, 32'd1000, 32'd1010, 32'd990, 32'd1005}, 1'b1, NOT_READY},
    '{'{1'b0, 32'd1000, 32'd1110, 32'd995, 32'd1100}, 1'b1, NOT_READY},
    '{'{1'b0, 32'd1050, 32'd1160, 32'd1045, 32'd1150}, 1'b1, NOT_READY},
    '{'{1'b0, 32'd1100, 32'd1210, 32'd1095, 32'd1200}, 1'b1, NOT_READY},
    '{'{1'b0, 32'd1150, 32'd1260, 32'd1145, 32'd1250}, 1'b1, NOT_READY},
    // window ready from here: soldiers, hammers, engulfing, piercing, star, crows
    '{'{1'b0, 32'd1200, 32'd1310, 32'd1195, 32'd1300}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd1300, 32'd1302, 32'd1200, 32'd1310}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd1310, 32'd1400, 32'd1309, 32'd1300}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd1500, 32'd1510, 32'd1390, 32'd1400}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd1380, 32'd1530, 32'd1370, 32'd1520}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2000, 32'd2010, 32'd1795, 32'd1800}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd1750, 32'd1955, 32'd1745, 32'd1950}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd3000, 32'd3005, 32'd2495, 32'd2500}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2400, 32'd2420, 32'd2380, 32'd2410}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2450, 32'd2700, 32'd2440, 32'd2690}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2600, 32'd2605, 32'd2495, 32'd2500}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2550, 32'd2555, 32'd2445, 32'd2450}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd2500, 32'd2505, 32'd2395, 32'd2400}, 1'b0, NOT_READY},
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, NOT_READY},
    '{'{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NOT_READY},
    '{'{1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF}, 1'b1, NOT_READY}
  };

  string flag_names [NUM_OUT] = '{"window_ready", "hammer", "inverse_hammer", "engulfing",
                                  "piercing_line", "star", "white_soldiers", "black_crows"};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [4*FIELD_W-1:0]   in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [NUM_OUT-1:0]     out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [PCT_W-1:0]       cfg_wdata;

  // detector copy: ratio registers, two previous candles, series count
  logic [PCT_W-1:0] short_wick_pct = SHORT_WICK_RST;
  logic [PCT_W-1:0] long_body_pct  = LONG_BODY_RST;
  price_t           prev_open [2]  = '{default: '0};
  price_t           prev_high [2]  = '{default: '0};
  price_t           prev_low [2]   = '{default: '0};
  price_t           prev_close [2] = '{default: '0};
  int               seen           = 0;

  pattern_flags_t flags_due [$];
  candle_t        backlog [$];
  longint         level         = 64'd100000;
  int             errors        = 0;
  int             candles_sent  = 0;

  candlestick_pattern_detector #(
    .PRICE_WIDTH(FIELD_W),
    .MIN_HISTORY(MIN_HISTORY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic longint unsigned gap(input price_t a, input price_t b);
    return (a > b) ? 64'(a - b) : 64'(b - a);
  endfunction

  // exact integer form of wick < body * pct / 100
  function automatic logic wick_under(input longint unsigned wick, input longint unsigned body,
                                      input logic [PCT_W-1:0] pct);
    return (wick * 64'd100) < (body * 64'(pct));
  endfunction

  function automatic pattern_flags_t detect_patterns(input candle_t cd);
    price_t            o [3], h [3], l [3], c [3];
    longint unsigned   body [3], lw [3], uw [3];
    logic              grn [3], rd [3], lng [3];
    price_t            lo_end, hi_end;
    pattern_flags_t    f;
    int                i;
    o[0] = cd.open;
    h[0] = cd.high;
    l[0] = cd.low;
    c[0] = cd.close;
    for (i = 1; i < 3; i++) begin
      o[i] = prev_open[i-1];
      h[i] = prev_high[i-1];
      l[i] = prev_low[i-1];
      c[i] = prev_close[i-1];
    end
    if (cd.first) seen = 0;
    f = '0;
    f.window_ready = (seen >= MIN_HISTORY);
    for (i = 0; i < 3; i++) begin
      lo_end  = (c[i] < o[i]) ? c[i] : o[i];
      hi_end  = (c[i] < o[i]) ? o[i] : c[i];
      body[i] = gap(c[i], o[i]);
      lw[i]   = gap(l[i], lo_end);
      uw[i]   = gap(h[i], hi_end);
      grn[i]  = c[i] > o[i];
      rd[i]   = c[i] < o[i];
      lng[i]  = wick_under(lw[i], body[i], long_body_pct) &&
                wick_under(uw[i], body[i], long_body_pct);
    end
    if (f.window_ready) begin
      f.hammer         = body[0] < lw[0] && wick_under(uw[0], body[0], short_wick_pct);
      f.inverse_hammer = body[0] < uw[0] && wick_under(lw[0], body[0], short_wick_pct);
      f.engulfing      = body[0] > body[1] && h[0] > h[1] && l[0] < l[1] && grn[0] && rd[1];
      f.piercing_line  = lng[0] && lng[1] && grn[0] && rd[1] &&
                         (64'(c[0]) << 1) > (64'(c[1]) + 64'(o[1]));
      f.star           = grn[0] && body[1] < body[0] && o[1] < o[0] && c[1] < o[0] &&
                         rd[2] && body[2] > body[1] && o[1] < c[2] && c[1] < c[2];
      f.white_soldiers = grn[0] && grn[1] && grn[2] && lng[0] && lng[1] && lng[2] &&
                         o[0] > o[1] && c[0] > c[1] && o[1] > o[2] && c[1] > c[2];
      f.black_crows    = rd[0] && rd[1] && rd[2] && lng[0] && lng[1] && lng[2] &&
                         o[0] < o[1] && c[0] < c[1] && o[1] < o[2] && c[1] < c[2];
    end
    prev_open[1]  = prev_open[0];
    prev_high[1]  = prev_high[0];
    prev_low[1]   = prev_low[0];
    prev_close[1] = prev_close[0];
    prev_open[0]  = o[0];
    prev_high[0]  = h[0];
    prev_low[0]   = l[0];
    prev_close[0] = c[0];
    if (seen < COUNT_MAX) seen++;
    return f;
  endfunction

  function automatic price_t clip(input longint v);
    if (v < 0) return '0;
    if (v > 64'hFFFF_FFFF) return '1;
    return price_t'(v);
  endfunction

  // well-formed candle, wicks given as percent of the body
  function automatic candle_t shaped(input longint o, input longint c,
                                     input int lw_pct, input int uw_pct);
    longint  b, mn, mx;
    candle_t cd;
    mn       = (o < c) ? o : c;
    mx       = (o < c) ? c : o;
    b        = mx - mn;
    cd.first = 1'b0;
    cd.open  = clip(o);
    cd.close = clip(c);
    cd.low   = clip(mn - b * lw_pct / 100);
    cd.high  = clip(mx + b * uw_pct / 100);
    return cd;
  endfunction

  // queue one short run of candles shaped toward some pattern, or noise
  task automatic build_scenario();
    longint  sz, p, o, c, d;
    int      k, start, pick;
    candle_t cd;
    start = backlog.size();
    pick  = $urandom_range(0, 9);
    if (pick < 4)      sz = $urandom_range(4, 60);
    else if (pick < 9) sz = $urandom_range(100, 1000000);
    else               sz = $urandom_range(1 << 20, 1 << 27);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       level = 3 * sz;
        1:       level = 64'hFFFF_FFFF - 3 * sz;
        default: level = $urandom;
      endcase
    end
    p = level;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        d = $urandom_range(0, int'(sz));
        c = $urandom_range(0, 1) ? p + d : p - d;
        backlog.push_back(shaped(p, c, $urandom_range(0, 150), $urandom_range(0, 150)));
      end
      3: begin
        for (k = 0; k < 3; k++) begin
          o = p + k * sz / 2;
          backlog.push_back(shaped(o, o + sz, $urandom_range(0, 20), $urandom_range(0, 20)));
        end
      end
      4: begin
        for (k = 0; k < 3; k++) begin
          o = p - k * sz / 2;
          backlog.push_back(shaped(o, o - sz, $urandom_range(0, 20), $urandom_range(0, 20)));
        end
      end
      5: begin
        backlog.push_back(shaped(p + sz / 2, p - sz / 2, $urandom_range(10, 50),
                                 $urandom_range(10, 50)));
        backlog.push_back(shaped(p - sz, p + sz, $urandom_range(10, 60), $urandom_range(10, 60)));
      end
      6: begin
        backlog.push_back(shaped(p + sz, p - sz, $urandom_range(0, 20), $urandom_range(0, 20)));
        backlog.push_back(shaped(p - sz - sz / 4, p + sz / 2, $urandom_range(0, 20),
                                 $urandom_range(0, 20)));
      end
      7: begin
        backlog.push_back(shaped(p + 2 * sz, p, $urandom_range(0, 20), $urandom_range(0, 20)));
        d = $urandom_range(0, int'(sz / 16));
        backlog.push_back(shaped(p - sz / 4, p - sz / 4 + d, $urandom_range(0, 100),
                                 $urandom_range(0, 100)));
        backlog.push_back(shaped(p - sz / 8, p + sz, $urandom_range(0, 20), $urandom_range(0, 20)));
      end
      8: begin
        d = $urandom_range(1, int'(sz / 4) + 1);
        c = $urandom_range(0, 1) ? p + d : p - d;
        backlog.push_back(shaped(p, c, $urandom_range(150, 500), $urandom_range(0, 25)));
      end
      9: begin
        d = $urandom_range(1, int'(sz / 4) + 1);
        c = $urandom_range(0, 1) ? p + d : p - d;
        backlog.push_back(shaped(p, c, $urandom_range(0, 25), $urandom_range(150, 500)));
      end
      10: begin
        cd = {($urandom_range(0, 3) == 0), $urandom, $urandom, $urandom, $urandom};
        backlog.push_back(cd);
      end
      default: begin
        // flat candle, or every price pinned at a rail or random
        if ($urandom_range(0, 1) == 0) begin
          cd.first = 1'b0;
          cd.open  = clip(p);
          cd.close = clip(p);
          cd.low   = clip(p - $urandom_range(0, int'(sz)));
          cd.high  = clip(p + $urandom_range(0, int'(sz)));
        end else begin
          cd.first = 1'b0;
          cd.open  = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
          cd.high  = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
          cd.low   = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
          cd.close = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
        end
        backlog.push_back(cd);
      end
    endcase
    if ($urandom_range(0, 99) < 4) backlog[start].first = 1'b1;
    level = backlog[$].close;
  endtask

  task automatic send_candle(input candle_t cd, input logic typed, input pattern_flags_t fixed);
    pattern_flags_t f;
    if (!(candles_sent >= 300 && candles_sent < 420) && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cd.close, cd.low, cd.high, cd.open};
    in_tuser  <= cd.first;
    do @(posedge clk); while (!in_tready);
    f = detect_patterns(cd);
    flags_due.push_back(typed ? fixed : f);
    candles_sent++;
  endtask

  // ratio registers first, then an index with no register behind it
  task automatic write_ratios(input logic [PCT_W-1:0] sw, input logic [PCT_W-1:0] lb,
                              input logic [CFG_IDX_W-1:0] spare,
                              input logic [PCT_W-1:0] spare_val);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [PCT_W-1:0]     val [3];
    int                   k;
    idx = '{REG_SHORT_WICK, REG_LONG_BODY, spare};
    val = '{sw, lb, spare_val};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_SHORT_WICK: short_wick_pct = val[k];
        REG_LONG_BODY:  long_body_pct  = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ph, n, i;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SHORT_WICK;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++)
      send_candle(DIRECTED[i].cd, DIRECTED[i].typed, DIRECTED[i].flags);
    in_tvalid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      while (flags_due.size() != 0) @(posedge clk);
      case (ph)
        0: write_ratios(7'd0, 7'd0, REG_SPARE_A, 7'($urandom));
        1: write_ratios(7'd100, 7'd100, REG_SPARE_B, 7'($urandom));
        2: write_ratios(7'd127, 7'd127, REG_SPARE_A, 7'h7F);
        3: write_ratios(SHORT_WICK_RST, LONG_BODY_RST, REG_SPARE_B, 7'h00);
        4: write_ratios(7'd0, 7'd127, REG_SPARE_A, 7'($urandom));
        default: write_ratios(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                              REG_SPARE_B, 7'($urandom));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (backlog.size() == 0) build_scenario();
        send_candle(backlog.pop_front(), 1'b0, NOT_READY);
      end
      in_tvalid <= 1'b0;
    end

    while (flags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb_candlestick_pattern_detector OK");
    else
      $display("tb_candlestick_pattern_detector NOT OK");
    $finish;
  end

  // result side: random stalls, a quiet stretch, and two long hold-offs
  initial begin
    int holds_done;
    holds_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ((holds_done == 0 && candles_sent >= 90) || (holds_done == 1 && candles_sent >= 560))
      begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (64) @(posedge clk);
      end else begin
        out_tready <= (candles_sent >= 300 && candles_sent < 420) ||
                      ($urandom_range(0, 99) >= 16);
      end
    end
  end

  always @(posedge clk) begin : check_results
    pattern_flags_t want;
    int             k;
    if (rst_n && out_tvalid && out_tready) begin
      if (flags_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %b", $time, out_tdata);
      end else begin
        want = flags_due.pop_front();
        for (k = 0; k < NUM_OUT; k++) begin
          if (out_tdata[k] !== want[k]) begin
            errors++;
            $display("%0t: %s expected %0b actual %0b", $time, flag_names[k], want[k],
                     out_tdata[k]);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_candlestick_pattern_detector NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cpd_pkg.sv
rtl/cpd_candle_metrics.sv
rtl/cpd_pattern_logic.sv
rtl/candlestick_pattern_detector.sv
sim/tb_candlestick_pattern_detector.sv
